// ----- rtl/dalu_pkg.sv -----
// dalu_pkg: shared types, mode codes and the divide-by-ten helper
// for the decimal digit-serial alu; no dependencies

package dalu_pkg;

   // field widths
   localparam int MODE_W  = 2;
   localparam int DIGIT_W = 4;
   localparam int MULT_W  = 7;
   localparam int CARRY_W = 7;

   // widest dividend: 15 * 127 + 127 fits in 11 bits
   localparam int DIV_W  = 11;
   localparam int QUOT_W = 8;

   // reciprocal of ten scaled by 2^15, exact for dividends below 16384
   localparam int RECIP_SHIFT = 15;
   localparam logic [11:0] RECIP_TEN = 12'd3277;

   localparam logic [CARRY_W-1:0] CARRY_MAX = '1;

   // operation codes; code 3 falls into multiply
   localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;

   typedef struct packed {
      logic [QUOT_W-1:0]  quot;
      logic [DIGIT_W-1:0] rem;
   } div10_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic [CARRY_W-1:0] carry_out;
      logic               negative;
      logic               done_res;
   } result_type;

   // floor divide by ten through a reciprocal multiply
   function automatic div10_type div10(input logic [DIV_W-1:0] val);
      logic [DIV_W+11:0]  prod;
      logic [QUOT_W-1:0]  q;
      logic [DIV_W-1:0]   back;
      logic [DIV_W-1:0]   diff;
      div10_type          res;
      prod = {12'd0, val} * {{DIV_W{1'b0}}, RECIP_TEN};
      q    = prod[RECIP_SHIFT +: QUOT_W];
      back = {{(DIV_W-QUOT_W){1'b0}}, q} * DIV_W'(10);
      diff = val - back;
      res.quot = q;
      res.rem  = diff[DIGIT_W-1:0];
      return res;
   endfunction

endpackage

// ----- rtl/dalu_step.sv -----
// dalu_step: one digit step of add, subtract or multiply with the running carry
// depends on dalu_pkg

module dalu_step (
   input  logic [dalu_pkg::MODE_W-1:0]  mode,
   input  logic [dalu_pkg::DIGIT_W-1:0] digit_a,
   input  logic [dalu_pkg::DIGIT_W-1:0] digit_b,
   input  logic [dalu_pkg::MULT_W-1:0]  multiplier,
   input  logic                         first,
   input  logic                         last,
   input  logic [dalu_pkg::CARRY_W-1:0] carry,
   output dalu_pkg::result_type         result,
   output logic [dalu_pkg::CARRY_W-1:0] carry_next
);

   logic [dalu_pkg::CARRY_W-1:0] carry_in;
   logic [7:0]                   sum;
   logic [dalu_pkg::DIV_W-1:0]   prod;
   logic [8:0]                   diff;
   logic [8:0]                   neg_diff;
   logic [7:0]                   borrow_val;
   logic                         is_sub;
   logic                         sub_neg;
   logic [dalu_pkg::DIV_W-1:0]   dividend;
   dalu_pkg::div10_type          qr;
   logic [dalu_pkg::DIGIT_W-1:0] dig;
   logic [dalu_pkg::CARRY_W-1:0] new_carry;

   // carry is cleared on the least significant digit
   assign carry_in = first ? '0 : carry;

   // candidate values for each operation
   assign sum  = {4'd0, digit_a} + {4'd0, digit_b} + {1'b0, carry_in};
   assign prod = {7'd0, digit_a} * {4'd0, multiplier} + {4'd0, carry_in};
   assign diff = {5'd0, digit_a} - {5'd0, digit_b} - {2'd0, carry_in};
   assign neg_diff   = 9'd0 - diff;
   assign borrow_val = neg_diff[7:0] + 8'd9;
   assign sub_neg    = diff[8];

   // pick the one value that goes through the divide by ten
   always_comb begin
      is_sub = 1'b0;
      case (mode)
         dalu_pkg::MODE_ADD: dividend = {3'd0, sum};
         dalu_pkg::MODE_SUB: begin
            is_sub   = 1'b1;
            dividend = sub_neg ? {3'd0, borrow_val} : {2'd0, diff};
         end
         default:            dividend = prod;
      endcase
   end

   assign qr = dalu_pkg::div10(dividend);

   // digit and new carry; a borrow of n gives digit 10n - |d| = 9 - rem
   always_comb begin
      if (is_sub) begin
         if (sub_neg) begin
            dig       = 4'd9 - qr.rem;
            new_carry = qr.quot[dalu_pkg::CARRY_W-1:0];
         end else begin
            dig       = qr.rem;
            new_carry = '0;
         end
      end else begin
         dig = qr.rem;
         if (qr.quot > {1'b0, dalu_pkg::CARRY_MAX})
            new_carry = dalu_pkg::CARRY_MAX;
         else
            new_carry = qr.quot[dalu_pkg::CARRY_W-1:0];
      end
   end

   assign carry_next       = new_carry;
   assign result.digit     = dig;
   assign result.carry_out = (last && !is_sub) ? new_carry : '0;
   assign result.negative  = last && is_sub && (new_carry != '0);
   assign result.done_res  = last;

endmodule

// ----- rtl/decimal_digit_serial_alu.sv -----
// decimal_digit_serial_alu: top level, input register, carry register and result register
// depends on dalu_pkg and dalu_step
//
//   channel | ports  | word
//   --------+--------+-------------------------------------------------
//   input   | req_*  | mode, digit_a, digit_b, multiplier, first, last
//   result  | rsp_*  | digit, carry_out, negative, done_res
//
// one word per cycle unless the result side stalls; the result is registered
// the digit step runs between the input register and the result register and
//   updates the carry register as the word moves on, so words may follow back to back
// reset clears both valid flags and the carry
// a stalled result holds the result register; the input register still takes one more word

module decimal_digit_serial_alu (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [dalu_pkg::MODE_W-1:0]  req_mode,
   input  logic [dalu_pkg::DIGIT_W-1:0] req_digit_a,
   input  logic [dalu_pkg::DIGIT_W-1:0] req_digit_b,
   input  logic [dalu_pkg::MULT_W-1:0]  req_multiplier,
   input  logic                         req_first,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [dalu_pkg::DIGIT_W-1:0] rsp_digit,
   output logic [dalu_pkg::CARRY_W-1:0] rsp_carry_out,
   output logic                         rsp_negative,
   output logic                         rsp_done_res
);

   logic                         in_valid_ff;
   logic [dalu_pkg::MODE_W-1:0]  mode_ff;
   logic [dalu_pkg::DIGIT_W-1:0] digit_a_ff;
   logic [dalu_pkg::DIGIT_W-1:0] digit_b_ff;
   logic [dalu_pkg::MULT_W-1:0]  multiplier_ff;
   logic                         first_ff;
   logic                         last_ff;
   logic [dalu_pkg::CARRY_W-1:0] carry_ff;
   logic [dalu_pkg::CARRY_W-1:0] carry_in;
   logic                         out_valid_ff;
   dalu_pkg::result_type         result_ff;
   dalu_pkg::result_type         result_in;
   logic                         advance;
   logic                         take;

   // stage handshake
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mode_ff       <= req_mode;
         digit_a_ff    <= req_digit_a;
         digit_b_ff    <= req_digit_b;
         multiplier_ff <= req_multiplier;
         first_ff      <= req_first;
         last_ff       <= req_last;
      end
   end

   // digit step
   dalu_step u_step (
      .mode       (mode_ff),
      .digit_a    (digit_a_ff),
      .digit_b    (digit_b_ff),
      .multiplier (multiplier_ff),
      .first      (first_ff),
      .last       (last_ff),
      .carry      (carry_ff),
      .result     (result_in),
      .carry_next (carry_in)
   );

   // running carry
   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
      end else if (advance) begin
         carry_ff <= carry_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_digit     = result_ff.digit;
   assign rsp_carry_out = result_ff.carry_out;
   assign rsp_negative  = result_ff.negative;
   assign rsp_done_res  = result_ff.done_res;

`ifndef SYNTHESIS
   // result digit is always decimal
   a_digit_decimal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit <= 4'd9))
      else $error("result digit above nine");

   // carry out and negative only on the last digit
   a_flags_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_done_res) |-> (rsp_carry_out == '0 && !rsp_negative))
      else $error("flags set on a digit that is not last");

   // never both a carry out and a negative flag
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_negative && (rsp_carry_out != '0)))
      else $error("carry out and negative together");

   // a word held in the input register is not dropped
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input word lost");

   // carry only moves when a word passes the step
   a_carry_stable: assert property (@(posedge clock) disable iff (reset)
      !$past(advance) |-> $stable(carry_ff))
      else $error("carry changed without a word");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for decimal_digit_serial_alu, directed numbers then random ones
// depends on dalu_pkg and the decimal_digit_serial_alu rtl; predicts every result digit

module testbench;

   localparam int MODE_W  = dalu_pkg::MODE_W;
   localparam int DIGIT_W = dalu_pkg::DIGIT_W;
   localparam int MULT_W  = dalu_pkg::MULT_W;
   localparam int CARRY_W = dalu_pkg::CARRY_W;

   // code 3 has bit 1 set and so multiplies
   localparam logic [MODE_W-1:0] MODE_MUL_ALT = dalu_pkg::MODE_MUL | dalu_pkg::MODE_SUB;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 8;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode;
   logic [DIGIT_W-1:0]  req_digit_a;
   logic [DIGIT_W-1:0]  req_digit_b;
   logic [MULT_W-1:0]   req_multiplier;
   logic                req_first;
   logic                req_last;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DIGIT_W-1:0]  rsp_digit;
   logic [CARRY_W-1:0]  rsp_carry_out;
   logic                rsp_negative;
   logic                rsp_done_res;

   // predicted carry of the digit chain and digits still to come
   logic [CARRY_W-1:0]    bcd_carry = '0;
   dalu_pkg::result_type  expected_digits[$];
   int                    error_count = 0;
   int                    cycle_count = 0;
   int                    stall_left = 0;
   bit                    no_idle = 1'b0;

   decimal_digit_serial_alu u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_digit_a    (req_digit_a),
      .req_digit_b    (req_digit_b),
      .req_multiplier (req_multiplier),
      .req_first      (req_first),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit      (rsp_digit),
      .rsp_carry_out  (rsp_carry_out),
      .rsp_negative   (rsp_negative),
      .rsp_done_res   (rsp_done_res)
   );

   // clock, period 10
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // one digit step: result digit and the new carry or borrow
   function automatic dalu_pkg::result_type predict_digit(input logic [MODE_W-1:0] mode,
                                                          input logic [DIGIT_W-1:0] a,
                                                          input logic [DIGIT_W-1:0] b,
                                                          input logic [MULT_W-1:0] m,
                                                          input logic first,
                                                          input logic last);
      int                   c;
      int                   val;
      int                   nd;
      int                   dig;
      int                   next_carry;
      bit                   is_sub;
      dalu_pkg::result_type res;
      c = first ? 0 : int'(bcd_carry);
      is_sub = 1'b0;
      if ((mode & dalu_pkg::MODE_MUL) != 0) begin
         val = int'(a) * int'(m) + c;
         dig = val % 10;
         next_carry = val / 10;
      end else if (mode == dalu_pkg::MODE_SUB) begin
         is_sub = 1'b1;
         val = int'(a) - int'(b) - c;
         if (val >= 0) begin
            // a difference of ten or more keeps only its low digit
            dig = val % 10;
            next_carry = 0;
         end else begin
            nd = -val;
            next_carry = (nd + 9) / 10;
            dig = next_carry * 10 - nd;
         end
      end else begin
         val = int'(a) + int'(b) + c;
         dig = val % 10;
         next_carry = val / 10;
      end
      // carry saturates at the register's top
      if (next_carry > int'(dalu_pkg::CARRY_MAX))
         next_carry = int'(dalu_pkg::CARRY_MAX);
      bcd_carry = CARRY_W'(next_carry);
      res.digit = DIGIT_W'(dig);
      res.carry_out = (last && !is_sub) ? CARRY_W'(next_carry) : '0;
      res.negative = last && is_sub && (next_carry != 0);
      res.done_res = last;
      return res;
   endfunction

   // idle length: mostly short, a few long
   function automatic int pick_gap_len();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [DIGIT_W-1:0] pick_digit();
      if ($urandom_range(0, 9) == 0)
         return DIGIT_W'($urandom_range(0, 15));
      return DIGIT_W'($urandom_range(0, 9));
   endfunction

   function automatic logic [MULT_W-1:0] pick_multiplier();
      if ($urandom_range(0, 7) == 0)
         return MULT_W'($urandom_range(100, 127));
      return MULT_W'($urandom_range(0, 99));
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return MODE_MUL_ALT;
      else if (r < 4)
         return dalu_pkg::MODE_ADD;
      else if (r < 7)
         return dalu_pkg::MODE_SUB;
      return dalu_pkg::MODE_MUL;
   endfunction

   // send one word after a random gap and record its expected result
   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [DIGIT_W-1:0] a,
                            input logic [DIGIT_W-1:0] b, input logic [MULT_W-1:0] m,
                            input logic first, input logic last);
      int gap;
      gap = 0;
      if (!no_idle && $urandom_range(0, 2) == 0)
         gap = pick_gap_len();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_digit_a    <= a;
      req_digit_b    <= b;
      req_multiplier <= m;
      req_first      <= first;
      req_last       <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      expected_digits.push_back(predict_digit(mode, a, b, m, first, last));
   endtask

   // hold the input side until every result is back
   task automatic wait_all_digits();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_digits.size() != 0)
         @(posedge clock);
   endtask

   // 999 + 1, 0 + 0, 9 + 9
   task automatic test_add_digits();
      send_word(dalu_pkg::MODE_ADD, 4'd9, 4'd1, 7'd0, 1'b1, 1'b0);
      send_word(dalu_pkg::MODE_ADD, 4'd9, 4'd0, 7'd0, 1'b0, 1'b0);
      send_word(dalu_pkg::MODE_ADD, 4'd9, 4'd0, 7'd0, 1'b0, 1'b1);
      send_word(dalu_pkg::MODE_ADD, 4'd0, 4'd0, 7'd0, 1'b1, 1'b1);
      send_word(dalu_pkg::MODE_ADD, 4'd9, 4'd9, 7'd0, 1'b1, 1'b1);
   endtask

   // 100 - 1, 3 - 7 goes negative, 0 - 99 goes negative over two digits
   task automatic test_subtract_digits();
      send_word(dalu_pkg::MODE_SUB, 4'd0, 4'd1, 7'd0, 1'b1, 1'b0);
      send_word(dalu_pkg::MODE_SUB, 4'd0, 4'd0, 7'd0, 1'b0, 1'b0);
      send_word(dalu_pkg::MODE_SUB, 4'd1, 4'd0, 7'd0, 1'b0, 1'b1);
      send_word(dalu_pkg::MODE_SUB, 4'd3, 4'd7, 7'd0, 1'b1, 1'b1);
      send_word(dalu_pkg::MODE_SUB, 4'd0, 4'd9, 7'd0, 1'b1, 1'b0);
      send_word(dalu_pkg::MODE_SUB, 4'd0, 4'd9, 7'd0, 1'b0, 1'b1);
   endtask

   // 99 * 99, times zero, saturating carry, code 3 multiplies
   task automatic test_multiply_digits();
      send_word(dalu_pkg::MODE_MUL, 4'd9, 4'd0, 7'd99, 1'b1, 1'b0);
      send_word(dalu_pkg::MODE_MUL, 4'd9, 4'd5, 7'd99, 1'b0, 1'b1);
      send_word(dalu_pkg::MODE_MUL, 4'd7, 4'd9, 7'd0, 1'b1, 1'b1);
      send_word(dalu_pkg::MODE_MUL, 4'd15, 4'd15, 7'd127, 1'b1, 1'b0);
      send_word(dalu_pkg::MODE_MUL, 4'd15, 4'd0, 7'd127, 1'b0, 1'b1);
      send_word(MODE_MUL_ALT, 4'd8, 4'd3, 7'd9, 1'b1, 1'b1);
   endtask

   // digits above nine, mixed modes on one chain, carry kept past last
   task automatic test_odd_digits();
      send_word(dalu_pkg::MODE_ADD, 4'd15, 4'd15, 7'd0, 1'b1, 1'b1);
      send_word(dalu_pkg::MODE_SUB, 4'd15, 4'd0, 7'd0, 1'b1, 1'b1);
      send_word(dalu_pkg::MODE_MUL, 4'd9, 4'd0, 7'd50, 1'b1, 1'b0);
      send_word(dalu_pkg::MODE_SUB, 4'd0, 4'd0, 7'd0, 1'b0, 1'b0);
      send_word(dalu_pkg::MODE_ADD, 4'd0, 4'd0, 7'd0, 1'b0, 1'b1);
      send_word(dalu_pkg::MODE_ADD, 4'd9, 4'd9, 7'd0, 1'b1, 1'b1);
      send_word(dalu_pkg::MODE_ADD, 4'd0, 4'd0, 7'd0, 1'b0, 1'b1);
      send_word(dalu_pkg::MODE_SUB, 4'd0, 4'd15, 7'd0, 1'b1, 1'b1);
   endtask

   // whole numbers with random digits, a few broken sequences between them
   task automatic test_random_numbers(input int count);
      int               sent;
      int               len;
      logic [MODE_W-1:0] mode;
      logic [MULT_W-1:0] m;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 6) == 0) begin
            send_word(MODE_W'($urandom_range(0, 3)), DIGIT_W'($urandom_range(0, 15)),
                      DIGIT_W'($urandom_range(0, 15)), MULT_W'($urandom_range(0, 127)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            mode = pick_mode();
            m = pick_multiplier();
            for (int i = 0; i < len; i++)
               send_word(mode, pick_digit(), pick_digit(), m, i == 0, i == len - 1);
            sent += len;
         end
      end
   endtask

   // numbers, then a full drain with the receiver still stalling, then more
   task automatic test_drain_pause();
      test_random_numbers(40);
      wait_all_digits();
      test_random_numbers(40);
   endtask

   // back to back words with no idling on either side
   task automatic test_no_idle();
      no_idle = 1'b1;
      test_random_numbers(300);
      no_idle = 1'b0;
   endtask

   // fully random words, modes mixed freely
   task automatic test_random_noise(input int count);
      for (int i = 0; i < count; i++)
         send_word(MODE_W'($urandom_range(0, 3)), DIGIT_W'($urandom_range(0, 15)),
                   DIGIT_W'($urandom_range(0, 15)), MULT_W'($urandom_range(0, 127)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // receiver stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = pick_gap_len() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each result word with the oldest expected digit
   always @(posedge clock) begin
      dalu_pkg::result_type exp_word;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_digits.size() == 0) begin
            $error("result word with no expected digit");
            error_count++;
         end else begin
            exp_word = expected_digits.pop_front();
            if (rsp_digit !== exp_word.digit) begin
               $error("digit: expected %0d, got %0d", exp_word.digit, rsp_digit);
               error_count++;
            end
            if (rsp_carry_out !== exp_word.carry_out) begin
               $error("carry_out: expected %0d, got %0d", exp_word.carry_out, rsp_carry_out);
               error_count++;
            end
            if (rsp_negative !== exp_word.negative) begin
               $error("negative: expected %0d, got %0d", exp_word.negative, rsp_negative);
               error_count++;
            end
            if (rsp_done_res !== exp_word.done_res) begin
               $error("done_res: expected %0d, got %0d", exp_word.done_res, rsp_done_res);
               error_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("decimal_digit_serial_alu test failed");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = dalu_pkg::MODE_ADD;
      req_digit_a    = '0;
      req_digit_b    = '0;
      req_multiplier = '0;
      req_first      = 1'b0;
      req_last       = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_add_digits();
      test_subtract_digits();
      test_multiply_digits();
      test_odd_digits();
      test_random_numbers(900);
      test_drain_pause();
      test_no_idle();
      test_random_noise(250);
      test_random_numbers(270);

      // drain and let the pipeline settle
      wait_all_digits();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("decimal_digit_serial_alu test passed");
      else
         $display("decimal_digit_serial_alu test failed");
      $finish;
   end

endmodule
